// ----- hdl/ptt_pkg.sv -----
package ptt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int RES_FIFO_DEPTH = 2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int ID_W   = 32;
  localparam int PER_W  = 32;
  localparam int TIME_W = 48;
  localparam int MUL_W  = 10;
  localparam int PROD_W = PER_W + MUL_W;

  localparam logic [MUL_W-1:0] US_PER_MS = MUL_W'(1000);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_DUP       = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  localparam logic [CFG_AW-3:0] REG_TIMER_MODE = '0;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_TICK
  } op_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   msg_id;
    logic [PER_W-1:0]  interval_ms;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] fired_id;
    logic [1:0]      status;
    logic            last;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   msg_id;
    logic [PER_W-1:0]  interval_ms;
    logic [TIME_W-1:0] now_us;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  period_ms;
    logic [TIME_W-1:0] start_us;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_NEW,
    ST_REM_RD,
    ST_REM_WR,
    ST_STATUS,
    ST_TICK_RD,
    ST_TICK_CALC,
    ST_TICK_EVAL,
    ST_FLUSH
  } eng_state_t;

endpackage

// ----- hdl/ptt_fifo.sv -----
module ptt_fifo
  import ptt_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign dout    = store_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- hdl/ptt_front.sv -----
module ptt_front
  import ptt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t in_data,
  output logic     full,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_pop
);

  job_t                  job_in;
  logic                  keep;
  logic [$bits(job_t)-1:0] job_bits;

  // Items with the unused command code are taken and dropped here.
  always_comb begin
    job_in.msg_id      = in_data.msg_id;
    job_in.interval_ms = in_data.interval_ms;
    job_in.now_us      = in_data.now_us;
    job_in.op          = OP_TICK;
    keep               = 1'b1;
    unique case (in_data.cmd)
      CMD_ADD:    job_in.op = OP_ADD;
      CMD_REMOVE: job_in.op = OP_REMOVE;
      CMD_TICK:   job_in.op = OP_TICK;
      default:    keep = 1'b0;
    endcase
  end

  ptt_fifo #(
    .W     ($bits(job_t)),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && keep),
    .din   (job_in),
    .full  (full),
    .pop   (job_pop),
    .dout  (job_bits),
    .valid (job_valid)
  );

  assign job = job_t'(job_bits);

endmodule

// ----- hdl/ptt_engine.sv -----
module ptt_engine
  import ptt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      timer_mode,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      res_push,
  output out_item_t res_item,
  input  logic      res_full
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  slot_t mem [SLOTS];
  slot_t rd_data_r;

  eng_state_t state_r, state_nxt;
  job_t       job_r, job_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic          found_r, found_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [ID_W-1:0] pend_id_r, pend_id_nxt;

  logic [TIME_W-1:0] el_r;
  logic [PROD_W-1:0] p_r;
  slot_t             ent_r;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic [IW-1:0] rd_addr;

  logic [CW-1:0] idx_inc, idx_dec, pos_inc;
  logic          key_ge, key_eq, tab_full, pos_last;
  logic          neg, fire, late, eval_stall;
  logic [TIME_W-1:0] new_start;
  logic [PROD_W-1:0] prod;

  assign idx_inc  = idx_r + CW'(1);
  assign idx_dec  = idx_r - CW'(1);
  assign pos_inc  = pos_r + CW'(1);
  assign key_ge   = (rd_data_r.id >= job_r.msg_id);
  assign key_eq   = (rd_data_r.id == job_r.msg_id);
  assign tab_full = (used_r == CW'(SLOTS));
  assign pos_last = (pos_inc == used_r);

  assign prod = PROD_W'(rd_data_r.period_ms) * PROD_W'(US_PER_MS);

  // A negative elapsed time restarts the timer; a timer more than two periods
  // late restarts at now even in absolute mode.
  assign neg        = el_r[TIME_W-1];
  assign fire       = !neg && (el_r > TIME_W'(p_r));
  assign late       = (el_r > TIME_W'({p_r, 1'b0}));
  assign new_start  = (neg || late || timer_mode) ? job_r.now_us
                                                  : ent_r.start_us + TIME_W'(p_r);
  assign eval_stall = fire && pend_v_r && res_full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          unique case (job.op) inside
            OP_ADD, OP_REMOVE: state_nxt = (used_r == '0) ? ST_DECIDE : ST_SRCH_RD;
            OP_TICK:           state_nxt = (used_r == '0) ? ST_IDLE : ST_TICK_RD;
            default:           state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SRCH_RD: state_nxt = ST_SRCH_CHK;
      ST_SRCH_CHK: begin
        if (key_ge || idx_inc == used_r) begin
          state_nxt = ST_DECIDE;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_DECIDE: begin
        if (job_r.op == OP_ADD) begin
          if (found_r || tab_full) begin
            state_nxt = ST_STATUS;
          end else if (pos_r == used_r) begin
            state_nxt = ST_INS_NEW;
          end else begin
            state_nxt = ST_INS_RD;
          end
        end else if (!found_r || pos_last) begin
          state_nxt = ST_STATUS;
        end else begin
          state_nxt = ST_REM_RD;
        end
      end
      ST_INS_RD:  state_nxt = ST_INS_WR;
      ST_INS_WR:  state_nxt = (idx_dec == pos_r) ? ST_INS_NEW : ST_INS_RD;
      ST_INS_NEW: state_nxt = ST_STATUS;
      ST_REM_RD:  state_nxt = ST_REM_WR;
      ST_REM_WR:  state_nxt = (idx_inc == used_r) ? ST_STATUS : ST_REM_RD;
      ST_STATUS: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK_RD:   state_nxt = ST_TICK_CALC;
      ST_TICK_CALC: state_nxt = ST_TICK_EVAL;
      ST_TICK_EVAL: begin
        if (!eval_stall) begin
          if (idx_inc == used_r) begin
            state_nxt = (pend_v_r || fire) ? ST_FLUSH : ST_IDLE;
          end else begin
            state_nxt = ST_TICK_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop     = 1'b0;
    job_nxt     = job_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    used_nxt    = used_r;
    status_nxt  = status_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r[IW-1:0];
    mem_wdata   = rd_data_r;
    rd_addr     = idx_r[IW-1:0];
    res_push    = 1'b0;
    res_item    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          job_nxt    = job;
          idx_nxt    = '0;
          pos_nxt    = '0;
          found_nxt  = 1'b0;
          pend_v_nxt = 1'b0;
        end
      end
      ST_SRCH_CHK: begin
        // The table is sorted, so the scan stops at the first id not below the key.
        if (key_ge) begin
          found_nxt = key_eq;
          pos_nxt   = idx_r;
        end else if (idx_inc == used_r) begin
          pos_nxt = used_r;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      ST_DECIDE: begin
        if (job_r.op == OP_ADD) begin
          if (found_r) begin
            status_nxt = STAT_DUP;
          end else if (tab_full) begin
            status_nxt = STAT_FULL;
          end else begin
            status_nxt = STAT_OK;
            idx_nxt    = used_r;
          end
        end else if (!found_r) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          status_nxt = STAT_OK;
          used_nxt   = used_r - CW'(1);
          idx_nxt    = pos_r;
        end
      end
      ST_INS_RD: rd_addr = idx_dec[IW-1:0];
      ST_INS_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_dec;
      end
      ST_INS_NEW: begin
        mem_we              = 1'b1;
        mem_waddr           = pos_r[IW-1:0];
        mem_wdata.id        = job_r.msg_id;
        mem_wdata.period_ms = job_r.interval_ms;
        mem_wdata.start_us  = job_r.now_us;
        used_nxt            = used_r + CW'(1);
      end
      ST_REM_RD: rd_addr = idx_inc[IW-1:0];
      ST_REM_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
      end
      ST_STATUS: begin
        res_item.kind   = KIND_STATUS;
        res_item.status = status_r;
        res_item.last   = 1'b1;
        res_push        = !res_full;
      end
      ST_TICK_EVAL: begin
        // A fired id is held back one step so that the last one can be marked.
        if (!eval_stall) begin
          if (neg || fire) begin
            mem_we             = 1'b1;
            mem_wdata          = ent_r;
            mem_wdata.start_us = new_start;
          end
          if (fire) begin
            pend_v_nxt  = 1'b1;
            pend_id_nxt = ent_r.id;
            if (pend_v_r) begin
              res_item.kind     = KIND_FIRED;
              res_item.fired_id = pend_id_r;
              res_item.status   = STAT_OK;
              res_push          = 1'b1;
            end
          end
          idx_nxt = idx_inc;
        end
      end
      ST_FLUSH: begin
        res_item.kind     = KIND_FIRED;
        res_item.fired_id = pend_id_r;
        res_item.status   = STAT_OK;
        res_item.last     = 1'b1;
        if (!res_full) begin
          res_push   = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= '0;
      pend_v_r <= 1'b0;
      idx_r    <= '0;
      pos_r    <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      pend_v_r <= pend_v_nxt;
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    status_r  <= status_nxt;
    pend_id_r <= pend_id_nxt;
    if (state_r == ST_TICK_CALC) begin
      el_r  <= job_r.now_us - rd_data_r.start_us;
      p_r   <= prod;
      ent_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(SLOTS))
    else $error("timer count exceeds table size");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_NEW) |=> (used_r == $past(used_r) + CW'(1)))
    else $error("insert did not grow the table");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_item.kind == KIND_STATUS) |-> res_item.last)
    else $error("status result not marked last");

endmodule

// ----- hdl/periodic_timer_table.sv -----
// Periodic timer table: up to SLOTS timers kept sorted by id in a table memory
// with one write port and a registered read port. An add or remove scans the
// table entry by entry (read, then check) up to the id, shifts the entries
// behind it one by one (read, then write), writes the new timer when one is
// inserted, and hands over its status once the result queue has room. A tick
// takes the command and then steps through each stored timer (read, elapsed and
// period product, compare and write back), and then hands over the last fired
// id; the scan waits whenever a fired id finds the result queue full.
// Commands wait in a two-entry queue and results in a two-entry queue, so the
// input side keeps taking items while results are not yet popped; timer_mode is
// read on every tick.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  in_item_t          in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic      mode_r, mode_nxt;
  logic      reg_sel;
  logic      job_valid, job_pop;
  job_t      job;
  logic      res_push, res_full, res_valid;
  out_item_t res_item;
  logic [$bits(out_item_t)-1:0] res_bits;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_AW-1:2] == REG_TIMER_MODE);
  assign prdata  = reg_sel ? CFG_DW'(mode_r) : '0;

  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && reg_sel) begin
      mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  ptt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  ptt_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .timer_mode (mode_r),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .res_push   (res_push),
    .res_item   (res_item),
    .res_full   (res_full)
  );

  ptt_fifo #(
    .W     ($bits(out_item_t)),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_item),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .valid (res_valid)
  );

  assign empty    = !res_valid;
  assign out_data = out_item_t'(res_bits);

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ptt_pkg::*;

  localparam logic [1:0]        CMD_UNUSED   = 2'd3;
  localparam logic [CFG_AW-1:0] MODE_ADDR    = CFG_AW'({REG_TIMER_MODE, 2'b00});
  localparam logic [63:0]       MS_TO_US     = 64'd1000;
  localparam int                POOL_SIZE    = 24;
  localparam int                PHASES       = 6;
  localparam int                PHASE_ITEMS  = 50;
  localparam int                DRAIN_CYCLES = 200;

  class timer_scoreboard;
    bit          mode;
    int          n_used;
    logic [31:0] tbl_id    [SLOTS_DEF];
    logic [31:0] tbl_per   [SLOTS_DEF];
    logic [47:0] tbl_start [SLOTS_DEF];
    out_item_t   due_results[$];
    int          errors;

    function logic [1:0] add_timer(logic [31:0] id, logic [31:0] per, logic [47:0] t_us);
      int pos;
      pos = 0;
      while (pos < n_used && tbl_id[pos] < id) pos++;
      if (pos < n_used && tbl_id[pos] == id) return STAT_DUP;
      if (n_used >= SLOTS_DEF) return STAT_FULL;
      for (int i = n_used; i > pos; i--) begin
        tbl_id[i]    = tbl_id[i-1];
        tbl_per[i]   = tbl_per[i-1];
        tbl_start[i] = tbl_start[i-1];
      end
      tbl_id[pos]    = id;
      tbl_per[pos]   = per;
      tbl_start[pos] = t_us;
      n_used++;
      return STAT_OK;
    endfunction

    function logic [1:0] remove_timer(logic [31:0] id);
      int pos;
      pos = 0;
      while (pos < n_used && tbl_id[pos] != id) pos++;
      if (pos >= n_used) return STAT_NOT_FOUND;
      for (int i = pos; i + 1 < n_used; i++) begin
        tbl_id[i]    = tbl_id[i+1];
        tbl_per[i]   = tbl_per[i+1];
        tbl_start[i] = tbl_start[i+1];
      end
      n_used--;
      return STAT_OK;
    endfunction

    // Works out the results of one accepted item and queues them in order.
    function void apply_item(in_item_t it);
      out_item_t   r;
      out_item_t   fired[$];
      logic [47:0] el;
      logic [63:0] p;
      r = '0;
      case (it.cmd)
        CMD_ADD: begin
          r.kind   = KIND_STATUS;
          r.status = add_timer(it.msg_id, it.interval_ms, it.now_us);
          r.last   = 1'b1;
          due_results.push_back(r);
        end
        CMD_REMOVE: begin
          r.kind   = KIND_STATUS;
          r.status = remove_timer(it.msg_id);
          r.last   = 1'b1;
          due_results.push_back(r);
        end
        CMD_TICK: begin
          for (int i = 0; i < n_used; i++) begin
            el = it.now_us - tbl_start[i];
            p  = 64'(tbl_per[i]) * MS_TO_US;
            // A start in the future (negative elapsed) is pulled back to now.
            if (el[47]) begin
              tbl_start[i] = it.now_us;
            end else if (64'(el) > p) begin
              if (64'(el) > (p << 1) || mode)
                tbl_start[i] = it.now_us;
              else
                tbl_start[i] = tbl_start[i] + p[47:0];
              r          = '0;
              r.kind     = KIND_FIRED;
              r.fired_id = tbl_id[i];
              fired.push_back(r);
            end
          end
          foreach (fired[j]) begin
            r      = fired[j];
            r.last = (j == fired.size() - 1);
            due_results.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d fired_id %h status %0d last %0d",
               got.kind, got.fired_id, got.status, got.last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.fired_id !== want.fired_id) begin
        $error("fired_id: expected %h, actual %h", want.fired_id, got.fired_id);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              push;
  in_item_t          in_data;
  logic              full;
  logic              empty;
  logic              pop;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  timer_scoreboard sb = new;
  bit              tx_stall_on = 1'b1;
  int              tx_items;
  logic [47:0]     cur_now;
  logic [31:0]     id_pool [POOL_SIZE];

  periodic_timer_table i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic in_item_t mk_item(logic [1:0] c, logic [31:0] id, logic [31:0] per,
                                       logic [47:0] t_us);
    in_item_t it;
    it.cmd         = c;
    it.msg_id      = id;
    it.interval_ms = per;
    it.now_us      = t_us;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    tx_items++;
    if (tx_items % 30 == 0) tx_stall_on = ($urandom_range(0, 2) != 0);
    gap = tx_stall_on ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    sb.apply_item(it);
  endtask

  // Holds the sender off until every queued result is out, then lets the
  // block finish any item that produces no result.
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= CFG_DW'(m);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.mode = m;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(m)) begin
      $error("timer_mode readback: expected %0d, actual %0d", m, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random pop stalls, with stretches where pop stays high.
  initial begin
    int  w;
    int  rx_items;
    bit  rx_stall_on;
    rx_items    = 0;
    rx_stall_on = 1'b1;
    pop         = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      rx_items++;
      if (rx_items % 20 == 0) rx_stall_on = ($urandom_range(0, 2) != 0);
      w = rx_stall_on ? $urandom_range(0, 16) : 0;
      repeat (w) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(out_data);
    end
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [1:0]  c;
    logic [31:0] id;
    logic [31:0] per;
    logic [47:0] base;
    int          k;
    int          n;

    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, in absolute mode straight out of reset. The base time sits
    // just below the 48-bit wrap so that the later ticks cross it.
    base = 48'hFFFF_FFFF_F000;
    send_item(mk_item(CMD_REMOVE, 32'd5, 32'd0, base));
    send_item(mk_item(CMD_TICK, 32'd0, 32'd0, base));
    send_item(mk_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, base));
    send_item(mk_item(CMD_ADD, 32'h0000_0000, 32'd0, base));
    send_item(mk_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, base));
    send_item(mk_item(CMD_ADD, 32'h0000_0000, 32'd7, base));
    send_item(mk_item(CMD_ADD, 32'd100, 32'd1, base));
    send_item(mk_item(CMD_ADD, 32'd50, 32'd2, base));
    send_item(mk_item(CMD_TICK, 32'd0, 32'd0, base + 48'd1500));
    send_item(mk_item(CMD_TICK, 32'd0, 32'd0, base + 48'd500));
    send_item(mk_item(CMD_TICK, 32'd0, 32'd0, base + 48'd5500));
    send_item(mk_item(CMD_REMOVE, 32'd50, 32'd0, base + 48'd5500));
    cur_now = base + 48'd5600;
    for (int i = 2; i < 15; i++)
      send_item(mk_item(CMD_ADD, id_pool[i], $urandom_range(0, 3), cur_now));
    send_item(mk_item(CMD_ADD, id_pool[15], 32'd1, cur_now));
    send_item(mk_item(CMD_ADD, id_pool[2], 32'd1, cur_now));
    cur_now = cur_now + 48'd20000;
    send_item(mk_item(CMD_TICK, 32'd0, 32'd0, cur_now));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_mode(ph % 2 == 0);
      if (ph % 3 == 1) cur_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100000));
      n = 0;
      while (n < PHASE_ITEMS) begin
        k = $urandom_range(0, 99);
        if (k < 3)
          c = CMD_UNUSED;
        else if (sb.n_used < 4)
          c = (k < 63) ? CMD_ADD : (k < 73) ? CMD_REMOVE : CMD_TICK;
        else if (sb.n_used >= 14)
          c = (k < 38) ? CMD_ADD : (k < 63) ? CMD_REMOVE : CMD_TICK;
        else
          c = (k < 43) ? CMD_ADD : (k < 63) ? CMD_REMOVE : CMD_TICK;
        id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom();
        k = $urandom_range(0, 99);
        if (k < 70)
          per = $urandom_range(0, 12);
        else if (k < 85)
          per = $urandom_range(13, 60);
        else
          per = $urandom();
        k = $urandom_range(0, 99);
        if (k < 4)
          cur_now = cur_now - 48'($urandom_range(1, 3000));
        else if (k < 6)
          cur_now = 48'({$urandom(), $urandom()});
        else if (k < 9)
          cur_now = cur_now + 48'($urandom_range(5000, 200000));
        else
          cur_now = cur_now + 48'($urandom_range(0, 3000));
        send_item(mk_item(c, id, per, cur_now));
        if (c != CMD_UNUSED) n++;
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
